@@ rtl/xcode_pkg.sv @@
// ----------------------------------------------------------------------------
// xcode_pkg
// Shared types, codes and the UTF-8 encoder for the text transcoder.
// ----------------------------------------------------------------------------
package xcode_pkg;

  localparam logic [1:0] ENC_LATIN1   = 2'd0;
  localparam logic [1:0] ENC_UTF16_BOM = 2'd1;
  localparam logic [1:0] ENC_UTF16_BE = 2'd2;
  localparam logic [1:0] ENC_UTF8     = 2'd3;

  localparam logic CFG_SRC_ENC   = 1'b0;
  localparam logic CFG_OUT_LIMIT = 1'b1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_BAD_MARK = 3'd2;
  localparam logic [2:0] ST_TOO_LONG = 3'd3;
  localparam logic [2:0] ST_BAD_SURR = 3'd4;

  localparam logic [1:0] POS_MARK0 = 2'd0;
  localparam logic [1:0] POS_MARK1 = 2'd1;
  localparam logic [1:0] POS_DATA  = 2'd2;

  typedef struct packed {
    logic [1:0]  src_enc;
    logic [15:0] out_limit;
  } cfg_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n;
  } utf8_seq_t;

  // one queued item: up to four bytes plus end-of-string info
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            has_data;
    logic            last;
    logic [2:0]      status;
  } entry_t;

  function automatic utf8_seq_t encode_point(input logic [20:0] cp);
    utf8_seq_t s;
    s.bytes = '0;
    if (cp[20:7] == '0) begin
      s.bytes[0] = cp[7:0];
      s.n = 3'd1;
    end else if (cp[20:11] == '0) begin
      s.bytes[0] = {3'b110, cp[10:6]};
      s.bytes[1] = {2'b10, cp[5:0]};
      s.n = 3'd2;
    end else if (cp[20:16] == '0) begin
      s.bytes[0] = {4'b1110, cp[15:12]};
      s.bytes[1] = {2'b10, cp[11:6]};
      s.bytes[2] = {2'b10, cp[5:0]};
      s.n = 3'd3;
    end else begin
      s.bytes[0] = {5'b11110, cp[20:18]};
      s.bytes[1] = {2'b10, cp[17:12]};
      s.bytes[2] = {2'b10, cp[11:6]};
      s.bytes[3] = {2'b10, cp[5:0]};
      s.n = 3'd4;
    end
    return s;
  endfunction

endpackage

@@ rtl/xcode_front.sv @@
// ----------------------------------------------------------------------------
// xcode_front
// Decodes source bytes into UTF-8 byte groups, tracks mark, surrogate and
// limit state, and hands one queue entry per productive transfer.
// ----------------------------------------------------------------------------
module xcode_front #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  xcode_pkg::cfg_t      cfg_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 byte_present_i,
  input  logic                 last_in_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 push_o,
  output xcode_pkg::entry_t    entry_o,
  input  logic                 full_i
);
  import xcode_pkg::*;

  logic [1:0]             pos_q, pos_d;
  logic [7:0]             mark_q, mark_d;
  logic                   le_q, le_d;
  logic [7:0]             held_q, held_d;
  logic                   held_vld_q, held_vld_d;
  logic [9:0]             hs_q, hs_d;
  logic                   pend_q, pend_d;
  logic [COUNT_WIDTH:0]   cnt_q, cnt_d;
  logic [2:0]             fault_q, fault_d;

  logic [COUNT_WIDTH+15:0] lim_wide;
  logic [COUNT_WIDTH-1:0]  limit;
  logic                    accept;

  assign lim_wide   = {{COUNT_WIDTH{1'b0}}, cfg_i.out_limit};
  assign limit      = lim_wide[COUNT_WIDTH-1:0];
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    utf8_seq_t            seq;
    logic [15:0]          u;
    logic [COUNT_WIDTH+1:0] sum;
    logic [2:0]           st;
    pos_d      = pos_q;
    mark_d     = mark_q;
    le_d       = le_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    hs_d       = hs_q;
    pend_d     = pend_q;
    cnt_d      = cnt_q;
    fault_d    = fault_q;
    seq        = '0;
    u          = '0;
    sum        = '0;
    st         = ST_OK;

    if (byte_present_i && fault_q == '0) begin
      if (cfg_i.src_enc == ENC_LATIN1) begin
        pos_d = POS_DATA;
        seq   = encode_point({13'd0, in_byte_i});
      end else if (cfg_i.src_enc == ENC_UTF8) begin
        pos_d        = POS_DATA;
        seq.bytes[0] = in_byte_i;
        seq.n        = 3'd1;
      end else if (cfg_i.src_enc == ENC_UTF16_BOM && pos_q == POS_MARK0) begin
        mark_d = in_byte_i;
        pos_d  = POS_MARK1;
      end else if (cfg_i.src_enc == ENC_UTF16_BOM && pos_q == POS_MARK1) begin
        if (mark_q == 8'hff && in_byte_i == 8'hfe) begin
          le_d = 1'b1;
        end else if (mark_q == 8'hfe && in_byte_i == 8'hff) begin
          le_d = 1'b0;
        end else begin
          fault_d = ST_BAD_MARK;
        end
        pos_d = POS_DATA;
      end else begin
        if (cfg_i.src_enc == ENC_UTF16_BE) begin
          le_d  = 1'b0;
          pos_d = POS_DATA;
        end
        if (!held_vld_q) begin
          held_d     = in_byte_i;
          held_vld_d = 1'b1;
        end else begin
          held_vld_d = 1'b0;
          u = le_d ? {in_byte_i, held_q} : {held_q, in_byte_i};
          if (pend_q) begin
            pend_d = 1'b0;
            if (u[15:10] == 6'b110111) begin
              seq = encode_point(21'h10000 + {1'b0, hs_q, u[9:0]});
            end else begin
              fault_d = ST_BAD_SURR;
            end
          end else if (u[15:10] == 6'b110110) begin
            hs_d   = u[9:0];
            pend_d = 1'b1;
          end else if (u[15:10] == 6'b110111) begin
            fault_d = ST_BAD_SURR;
          end else begin
            seq = encode_point({5'd0, u});
          end
        end
      end

      if (seq.n != '0) begin
        sum = {1'b0, cnt_q} + (COUNT_WIDTH+2)'(seq.n);
        if (sum > {2'b00, limit}) begin
          fault_d = ST_TOO_LONG;
          seq.n   = '0;
        end else begin
          cnt_d = sum[COUNT_WIDTH:0];
        end
      end
    end

    if (fault_d != '0) begin
      st = fault_d;
    end else if (cfg_i.src_enc == ENC_UTF16_BOM && pos_d < POS_DATA) begin
      st = ST_BAD_MARK;
    end else if (pend_d) begin
      st = ST_BAD_SURR;
    end else if (cnt_d == '0) begin
      st = ST_EMPTY;
    end else begin
      st = ST_OK;
    end

    entry_o.bytes    = seq.bytes;
    entry_o.has_data = (seq.n != '0);
    entry_o.last_idx = (seq.n != '0) ? 2'(seq.n - 3'd1) : 2'd0;
    entry_o.last     = last_in_i;
    entry_o.status   = last_in_i ? st : ST_OK;
    push_o           = accept && ((seq.n != '0) || last_in_i);

    if (last_in_i) begin
      pos_d      = POS_MARK0;
      mark_d     = '0;
      le_d       = 1'b0;
      held_d     = '0;
      held_vld_d = 1'b0;
      hs_d       = '0;
      pend_d     = 1'b0;
      cnt_d      = '0;
      fault_d    = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= POS_MARK0;
      mark_q     <= '0;
      le_q       <= 1'b0;
      held_q     <= '0;
      held_vld_q <= 1'b0;
      hs_q       <= '0;
      pend_q     <= 1'b0;
      cnt_q      <= '0;
      fault_q    <= ST_OK;
    end else if (accept) begin
      pos_q      <= pos_d;
      mark_q     <= mark_d;
      le_q       <= le_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
      hs_q       <= hs_d;
      pend_q     <= pend_d;
      cnt_q      <= cnt_d;
      fault_q    <= fault_d;
    end
  end

endmodule

@@ rtl/xcode_fifo.sv @@
// ----------------------------------------------------------------------------
// xcode_fifo
// Two-entry queue of decoded byte groups between front and back.
// ----------------------------------------------------------------------------
module xcode_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  xcode_pkg::entry_t  entry_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output xcode_pkg::entry_t  entry_o
);
  import xcode_pkg::*;

  entry_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;

  assign full_o  = (fill_q == 2'd2);
  assign valid_o = (fill_q != 2'd0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      fill_q <= fill_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

@@ rtl/xcode_back.sv @@
// ----------------------------------------------------------------------------
// xcode_back
// Serializes queued byte groups into single result transfers through an
// output register.
// ----------------------------------------------------------------------------
module xcode_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  xcode_pkg::entry_t  entry_i,
  output logic               pop_o,
  output logic [7:0]         out_byte_o,
  output logic               byte_valid_o,
  output logic               out_last_o,
  output logic [2:0]         status_o,
  output logic               out_valid_o,
  input  logic               out_ready_i
);
  import xcode_pkg::*;

  logic [1:0] idx_q;
  logic       vld_q;
  logic [7:0] byte_q;
  logic       bvld_q, last_q;
  logic [2:0] st_q;
  logic       load, final_byte;

  assign load       = valid_i && (!vld_q || out_ready_i);
  assign final_byte = (idx_q == entry_i.last_idx);
  assign pop_o      = load && final_byte;

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= entry_i.has_data ? entry_i.bytes[idx_q] : 8'd0;
      bvld_q <= entry_i.has_data;
      last_q <= entry_i.last && final_byte;
      st_q   <= (entry_i.last && final_byte) ? entry_i.status : ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      if (load) begin
        vld_q <= 1'b1;
        idx_q <= final_byte ? 2'd0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = vld_q;
  assign out_byte_o   = byte_q;
  assign byte_valid_o = bvld_q;
  assign out_last_o   = last_q;
  assign status_o     = st_q;

endmodule

@@ rtl/text_to_utf8_transcoder.sv @@
// ----------------------------------------------------------------------------
// text_to_utf8_transcoder
// Converts Latin-1, UTF-16 (with or without byte order mark) or UTF-8 text
// into a UTF-8 byte stream with an end-of-string status.
// ----------------------------------------------------------------------------
// The input side takes one source byte per cycle while the queue is not full
// and decodes it into a group of zero to four UTF-8 bytes, queued in a
// two-entry buffer. The output side sends one UTF-8 byte per cycle from a
// registered stage while out_ready is high, so an item is sent as one transfer
// per byte it yields (at least one transfer, four for a character outside the
// basic plane); the output serializer sets the sustained rate. The last
// transfer of each string carries out_last and the status; a string whose
// final item yields no byte gets one transfer with byte_valid low.
// Configuration must be written only while the block is idle; the block
// itself does not enforce this.
module text_to_utf8_transcoder #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic [7:0]  in_byte_i,
  input  logic        byte_present_i,
  input  logic        last_in_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        out_last_o,
  output logic [2:0]  status_o,
  output logic        out_valid_o,
  input  logic        out_ready_i
);
  import xcode_pkg::*;

  cfg_t   cfg_q;
  logic   push, full, pop, q_valid;
  entry_t push_entry, head_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_enc   <= ENC_LATIN1;
      cfg_q.out_limit <= 16'd1023;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SRC_ENC:   cfg_q.src_enc   <= cfg_wdata_i[1:0];
        CFG_OUT_LIMIT: cfg_q.out_limit <= cfg_wdata_i;
        default:       cfg_q           <= cfg_q;
      endcase
    end
  end

  xcode_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_byte_i     (in_byte_i),
    .byte_present_i(byte_present_i),
    .last_in_i     (last_in_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .push_o        (push),
    .entry_o       (push_entry),
    .full_i        (full)
  );

  xcode_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .entry_o(head_entry)
  );

  xcode_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .entry_i     (head_entry),
    .pop_o       (pop),
    .out_byte_o  (out_byte_o),
    .byte_valid_o(byte_valid_o),
    .out_last_o  (out_last_o),
    .status_o    (status_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

endmodule
